/* rtl/team_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_pkg
// Shared constants and types of the triangle edge adjacency matcher.
// ----------------------------------------------------------------------------
package team_pkg;

    localparam int VERTEX_W          = 16;
    localparam int TRI_NUM_W         = 10;
    localparam int POS_W             = 2;
    localparam int OUTCOME_W         = 2;
    localparam int EDGES_PER_TRI     = 3;
    localparam int MAX_TRIANGLES_DEF = 1024;
    localparam int VERTEX_BITS_DEF   = 16;

    // Neighbor fields carry this value when an edge has no twin.
    localparam logic [TRI_NUM_W-1:0] NO_NEIGHBOR = '0;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_OPEN     = 2'd0,
        OUTCOME_LINKED   = 2'd1,
        OUTCOME_BORDER   = 2'd2,
        OUTCOME_REJECTED = 2'd3
    } outcome_t;

    localparam logic [POS_W-1:0] POS_AB = 2'd0;
    localparam logic [POS_W-1:0] POS_BC = 2'd1;
    localparam logic [POS_W-1:0] POS_CA = 2'd2;

endpackage

/* rtl/team_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_in_if
// Triangle input channel: valid/ready handshake with three vertex indices.
// ----------------------------------------------------------------------------
interface team_in_if;
    logic                          valid;
    logic                          ready;
    logic                          new_mesh;
    logic [team_pkg::VERTEX_W-1:0] vertex_a;
    logic [team_pkg::VERTEX_W-1:0] vertex_b;
    logic [team_pkg::VERTEX_W-1:0] vertex_c;

    modport source (output valid, new_mesh, vertex_a, vertex_b, vertex_c, input ready);
    modport sink   (input valid, new_mesh, vertex_a, vertex_b, vertex_c, output ready);
endinterface

/* rtl/team_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_out_if
// Edge result channel: valid/ready handshake with one result per edge.
// ----------------------------------------------------------------------------
interface team_out_if;
    logic                           valid;
    logic                           ready;
    logic [team_pkg::TRI_NUM_W-1:0] triangle_number;
    logic [team_pkg::POS_W-1:0]     edge_position;
    logic [team_pkg::OUTCOME_W-1:0] outcome;
    logic [team_pkg::TRI_NUM_W-1:0] neighbor_triangle;
    logic [team_pkg::POS_W-1:0]     neighbor_edge;
    logic                           last;

    modport source (output valid, triangle_number, edge_position, outcome,
                    neighbor_triangle, neighbor_edge, last, input ready);
    modport sink   (input valid, triangle_number, edge_position, outcome,
                    neighbor_triangle, neighbor_edge, last, output ready);
endinterface

/* rtl/triangle_edge_adjacency_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_edge_adjacency_matcher
// Matches triangle edges to their twins through a hashed edge table.
// ----------------------------------------------------------------------------
// Usage: each transaction on tri_in carries one triangle (three vertex
// indices and a new_mesh flag). For every triangle, three transactions leave
// on edge_out, one per edge in the order a-b, b-c, c-a; the third has last
// set. Edges are keyed by their unordered vertex pair in a hashed table with
// linear probing, held in one synchronous RAM of 4*MAX_TRIANGLES entries
// (rounded up to a power of two). Each probe passes through a read state
// (S_PROBE) and a check state (S_CHECK); a slot holding another pair sends
// the probe on to the next slot. tri_in is ready only between triangles.
// A triangle beyond capacity yields three rejected results without any
// table access.
// After reset, and when new_mesh arrives while triangles are stored, the
// table is swept clear at one entry per cycle (table depth entries, 4096 at
// the default size) before the triangle is handled. A stalled edge_out
// holds its result and the block waits before loading the next one.
// ----------------------------------------------------------------------------
module triangle_edge_adjacency_matcher #(
    parameter int MAX_TRIANGLES = team_pkg::MAX_TRIANGLES_DEF,
    parameter int VERTEX_BITS   = team_pkg::VERTEX_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    team_in_if.sink    tri_in,
    team_out_if.source edge_out
);

    localparam int KEY_W   = (VERTEX_BITS < team_pkg::VERTEX_W) ? VERTEX_BITS
                                                                : team_pkg::VERTEX_W;
    localparam int CNT_W   = $clog2(MAX_TRIANGLES + 1);
    localparam int TRI_W   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int HB      = $clog2(4 * MAX_TRIANGLES);
    localparam int DEPTH   = 1 << HB;
    localparam int PAIR_W  = 2 * KEY_W;
    localparam int CHUNKS  = (PAIR_W + HB - 1) / HB;
    localparam int ENTRY_W = 2 + TRI_W + team_pkg::POS_W + PAIR_W;
    localparam int TN      = team_pkg::TRI_NUM_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EDGE  = 6'b000100,
        S_PROBE = 6'b001000,
        S_CHECK = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [KEY_W-1:0]           va_reg, vb_reg, vc_reg;
    logic [team_pkg::POS_W-1:0] edge_reg, edge_next;
    logic                       reject_reg, reject_next;
    logic                       pending_reg, pending_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [HB-1:0]              probe_reg, probe_next;
    logic [HB-1:0]              clr_reg, clr_next;
    logic [KEY_W-1:0]           lo_reg, hi_reg;
    team_pkg::outcome_t         res_outcome_reg, res_outcome_next;
    logic [TN-1:0]              res_ntri_reg, res_ntri_next;
    logic [team_pkg::POS_W-1:0] res_npos_reg, res_npos_next;
    logic                       out_valid_reg, out_valid_next;
    logic [TN-1:0]              out_tri_reg;
    logic [team_pkg::POS_W-1:0] out_pos_reg;
    team_pkg::outcome_t         out_outcome_reg;
    logic [TN-1:0]              out_ntri_reg;
    logic [team_pkg::POS_W-1:0] out_npos_reg;
    logic                       out_last_reg;

    logic                       accept, out_load;
    logic [KEY_W-1:0]           key_p, key_q, key_lo, key_hi;
    logic [CHUNKS*HB-1:0]       pair_pad;
    logic [HB-1:0]              hash;
    logic                       ram_we, ram_re;
    logic [HB-1:0]              ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata, ram_rdata;
    logic                       rd_valid, rd_linked;
    logic [TRI_W-1:0]           rd_tri;
    logic [team_pkg::POS_W-1:0] rd_pos;
    logic [KEY_W-1:0]           rd_hi, rd_lo;
    logic                       rd_match;
    logic [TRI_W+TN-1:0]        rd_tri_ext;
    logic [CNT_W+TN-1:0]        cnt_ext;

    assign tri_in.ready = (state_reg == S_IDLE);
    assign accept       = tri_in.valid && tri_in.ready;
    assign out_load     = (state_reg == S_EMIT) && (!out_valid_reg || edge_out.ready);

    // Endpoints of the current edge and its unordered key.
    always_comb
    begin
        case (edge_reg)
            team_pkg::POS_AB:
            begin
                key_p = va_reg;
                key_q = vb_reg;
            end
            team_pkg::POS_BC:
            begin
                key_p = vb_reg;
                key_q = vc_reg;
            end
            default:
            begin
                key_p = vc_reg;
                key_q = va_reg;
            end
        endcase
        key_lo = (key_p < key_q) ? key_p : key_q;
        key_hi = (key_p < key_q) ? key_q : key_p;
    end

    // XOR fold of the vertex pair down to a table address.
    always_comb
    begin
        pair_pad = (CHUNKS*HB)'({key_hi, key_lo});
        hash     = '0;
        for (int i = 0; i < CHUNKS; i++)
        begin
            hash = hash ^ pair_pad[i*HB +: HB];
        end
    end

    assign {rd_valid, rd_linked, rd_tri, rd_pos, rd_hi, rd_lo} = ram_rdata;
    assign rd_match   = (rd_hi == hi_reg) && (rd_lo == lo_reg);
    assign rd_tri_ext = {{TN{1'b0}}, rd_tri};
    assign cnt_ext    = {{TN{1'b0}}, cnt_reg};

    always_comb
    begin
        state_next       = state_reg;
        edge_next        = edge_reg;
        reject_next      = reject_reg;
        pending_next     = pending_reg;
        cnt_next         = cnt_reg;
        probe_next       = probe_reg;
        clr_next         = clr_reg;
        res_outcome_next = res_outcome_reg;
        res_ntri_next    = res_ntri_reg;
        res_npos_next    = res_npos_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = probe_reg;
        ram_wdata        = {1'b1, 1'b0, cnt_reg[TRI_W-1:0], edge_reg, hi_reg, lo_reg};

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {HB{1'b1}})
                begin
                    state_next   = pending_reg ? S_EDGE : S_IDLE;
                    pending_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    edge_next = team_pkg::POS_AB;
                    if (tri_in.new_mesh)
                    begin
                        cnt_next    = '0;
                        reject_next = 1'b0;
                        if (cnt_reg != '0)
                        begin
                            state_next   = S_CLEAR;
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_EDGE;
                        end
                    end
                    else
                    begin
                        reject_next = (cnt_reg >= CNT_W'(MAX_TRIANGLES));
                        state_next  = S_EDGE;
                    end
                end
            end
            S_EDGE:
            begin
                probe_next = hash;
                if (reject_reg)
                begin
                    res_outcome_next = team_pkg::OUTCOME_REJECTED;
                    res_ntri_next    = team_pkg::NO_NEIGHBOR;
                    res_npos_next    = '0;
                    state_next       = S_EMIT;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_ntri_next = team_pkg::NO_NEIGHBOR;
                res_npos_next = '0;
                if (!rd_valid)
                begin
                    ram_we           = 1'b1;
                    res_outcome_next = team_pkg::OUTCOME_OPEN;
                    state_next       = S_EMIT;
                end
                else if (rd_match)
                begin
                    state_next = S_EMIT;
                    if (rd_linked)
                    begin
                        res_outcome_next = team_pkg::OUTCOME_BORDER;
                    end
                    else
                    begin
                        // Mark the stored slot as linked; the new slot is never stored.
                        ram_we           = 1'b1;
                        ram_wdata        = {1'b1, 1'b1, rd_tri, rd_pos, rd_hi, rd_lo};
                        res_outcome_next = team_pkg::OUTCOME_LINKED;
                        res_ntri_next    = rd_tri_ext[TN-1:0];
                        res_npos_next    = rd_pos;
                    end
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (edge_reg == team_pkg::POS_CA)
                    begin
                        state_next = S_IDLE;
                        if (!reject_reg)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        edge_next  = edge_reg + 1'b1;
                        state_next = S_EDGE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (edge_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    team_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_edge_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (probe_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            edge_reg      <= team_pkg::POS_AB;
            reject_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edge_reg      <= edge_next;
            reject_reg    <= reject_next;
            pending_reg   <= pending_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg       <= probe_next;
        res_outcome_reg <= res_outcome_next;
        res_ntri_reg    <= res_ntri_next;
        res_npos_reg    <= res_npos_next;
        if (accept)
        begin
            va_reg <= tri_in.vertex_a[KEY_W-1:0];
            vb_reg <= tri_in.vertex_b[KEY_W-1:0];
            vc_reg <= tri_in.vertex_c[KEY_W-1:0];
        end
        if (state_reg == S_EDGE)
        begin
            lo_reg <= key_lo;
            hi_reg <= key_hi;
        end
        if (out_load)
        begin
            out_tri_reg     <= reject_reg ? '0 : cnt_ext[TN-1:0];
            out_pos_reg     <= edge_reg;
            out_outcome_reg <= res_outcome_reg;
            out_ntri_reg    <= res_ntri_reg;
            out_npos_reg    <= res_npos_reg;
            out_last_reg    <= (edge_reg == team_pkg::POS_CA);
        end
    end

    assign edge_out.valid             = out_valid_reg;
    assign edge_out.triangle_number   = out_tri_reg;
    assign edge_out.edge_position     = out_pos_reg;
    assign edge_out.outcome           = out_outcome_reg;
    assign edge_out.neighbor_triangle = out_ntri_reg;
    assign edge_out.neighbor_edge     = out_npos_reg;
    assign edge_out.last              = out_last_reg;

    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        edge_reg != 2'd3)
        else $error("edge position out of range");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TRIANGLES))
        else $error("triangle count above capacity");

    a_empty_slot_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !rd_valid) |=>
        (state_reg == S_EMIT && res_outcome_reg == team_pkg::OUTCOME_OPEN))
        else $error("empty table entry did not open a slot");

    a_last_on_third: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_out.valid && edge_out.last) |-> (edge_out.edge_position == team_pkg::POS_CA))
        else $error("last flag on an edge other than c-a");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && reject_reg) |=> (edge_out.outcome == team_pkg::OUTCOME_REJECTED))
        else $error("rejected triangle produced a table outcome");

endmodule

/* rtl/team_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module team_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
